// File: rtl/utf8d_pkg.sv
// Package for the UTF-8 validating decoder: types, byte constants and masks.
`timescale 1ns / 1ps

package utf8d_pkg;

  // Lead and range bytes
  localparam logic [7:0] AsciiMax     = 8'h7f;
  localparam logic [7:0] Lead2Min     = 8'hc2;
  localparam logic [7:0] Lead2Max     = 8'hdf;
  localparam logic [7:0] Lead3Min     = 8'he0;
  localparam logic [7:0] Lead3Max     = 8'hef;
  localparam logic [7:0] Lead4Min     = 8'hf0;
  localparam logic [7:0] Lead4Max     = 8'hf4;
  localparam logic [7:0] LeadSurr     = 8'hed;
  localparam logic [7:0] Second3Min   = 8'ha0;
  localparam logic [7:0] SecondSurMax = 8'h9f;
  localparam logic [7:0] Second4Min   = 8'h90;
  localparam logic [7:0] Second4Max   = 8'h8f;

  // Payload masks
  localparam logic [7:0] ContMask  = 8'h3f;
  localparam logic [7:0] Lead2Mask = 8'h1f;
  localparam logic [7:0] Lead3Mask = 8'h0f;
  localparam logic [7:0] Lead4Mask = 8'h07;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned CntWidth = 3;
  localparam logic [CntWidth-1:0] MaxGroup = 3'd4;

  // Pending sequence or malformed group
  typedef struct packed {
    logic [CpWidth-1:0]  partial_value;
    logic [7:0]          lead_byte;
    logic [CntWidth-1:0] bytes_held;
    logic [CntWidth-1:0] expected_length;
    logic                skipping_error;
  } dec_state_t;

  // One result item
  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic                invalid;
    logic [CntWidth-1:0] byte_count;
    logic                last_of_run;
  } result_t;

endpackage

// File: rtl/utf8_validating_decoder_core.sv
// Top level of the UTF-8 validating decoder: input register, decode step, result queue.
`timescale 1ns / 1ps
//
// Byte-stream UTF-8 decoder with validation.
// Input channel: one byte per item (data_byte_i) with end_of_text_i on the
// last byte of a text; in_valid_i / in_ready_o handshake.
// Output channel: one result per item (code point, invalid flag, byte count,
// last_of_run marking the final result caused by one input byte);
// out_valid_o / out_ready_i handshake.
// Path: a byte accepted into the input register is then decoded into the
// result queue; the decode waits while the queue lacks room.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver keeps up; a byte that gives two results needs an extra
// output slot, absorbed by the four-entry result queue. The queue must have
// room for two results before the held byte is decoded.
// Reset clears the decoder state, the input register and the queue.
// When the receiver stalls, results wait in the queue, and input is
// refused while a byte is held and the queue cannot take two more results.
//
module utf8_validating_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] code_point_o,
  output logic        invalid_o,
  output logic [2:0]  byte_count_o,
  output logic        last_of_run_o
);
  import utf8d_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);

  logic              in_valid_q;
  logic [7:0]        byte_q;
  logic              eot_q;
  dec_state_t        state_q;
  dec_state_t        state_d;
  result_t           res0;
  result_t           res1;
  logic [1:0]        res_num;
  logic              process;
  logic              pop;
  result_t           queue_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [PtrW:0]     cnt_q;
  result_t           head;

  // Decode the held byte once the queue has room for two results
  assign process    = in_valid_q && (cnt_q <= (PtrW+1)'(QDepth - 2));
  assign in_ready_o = !in_valid_q || process;
  assign pop        = out_valid_o && out_ready_i;

  utf8d_step u_step (
    .state_i       (state_q),
    .data_byte_i   (byte_q),
    .end_of_text_i (eot_q),
    .state_o       (state_d),
    .res0_o        (res0),
    .res1_o        (res1),
    .res_num_o     (res_num)
  );

  // Input register and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (process) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
      eot_q  <= end_of_text_i;
    end
  end

  // Result queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (process) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(res_num);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + (process ? (PtrW+1)'(res_num) : '0) - (PtrW+1)'(pop);
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (process && (res_num != 2'd0)) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (process && (res_num == 2'd2)) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  assign head          = queue_q[rd_ptr_q];
  assign out_valid_o   = (cnt_q != '0);
  assign code_point_o  = head.code_point;
  assign invalid_o     = head.invalid;
  assign byte_count_o  = head.byte_count;
  assign last_of_run_o = head.last_of_run;

endmodule

// File: rtl/utf8d_step.sv
// Combinational decode of one byte: next state and up to two result items.
`timescale 1ns / 1ps

module utf8d_step (
  input  utf8d_pkg::dec_state_t state_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_text_i,
  output utf8d_pkg::dec_state_t state_o,
  output utf8d_pkg::result_t    res0_o,
  output utf8d_pkg::result_t    res1_o,
  output logic [1:0]            res_num_o
);
  import utf8d_pkg::*;

  localparam dec_state_t Idle = '0;

  logic       start_byte;
  logic       is_cont;
  logic       sec_ok;
  logic       ok;
  logic       fresh;
  logic       emit_a;
  logic       emit_b;
  logic       emit_c;
  result_t    res_a;
  result_t    res_b;
  result_t    res_c;
  dec_state_t s;

  // Byte classes
  assign start_byte = (data_byte_i <= AsciiMax) ||
                      ((data_byte_i >= Lead2Min) && (data_byte_i <= Lead4Max));
  assign is_cont    = (data_byte_i[7:6] == 2'b10);

  // Second-byte range depends on the lead byte
  always_comb begin
    sec_ok = is_cont;
    if ((state_i.lead_byte == Lead3Min) && (data_byte_i < Second3Min)) sec_ok = 1'b0;
    if ((state_i.lead_byte == LeadSurr) && (data_byte_i > SecondSurMax)) sec_ok = 1'b0;
    if ((state_i.lead_byte == Lead4Min) && (data_byte_i < Second4Min)) sec_ok = 1'b0;
    if ((state_i.lead_byte == Lead4Max) && (data_byte_i > Second4Max)) sec_ok = 1'b0;
  end

  assign ok = (state_i.bytes_held == 3'd1) ? sec_ok : is_cont;

  // Decode step
  always_comb begin
    s      = state_i;
    fresh  = 1'b1;
    emit_a = 1'b0;
    emit_b = 1'b0;
    emit_c = 1'b0;
    res_a  = '0;
    res_b  = '0;
    res_c  = '0;

    // Held bytes: continue, join a group or close it
    if (state_i.bytes_held != '0) begin
      if (state_i.skipping_error || !ok) begin
        if (!start_byte) begin
          fresh            = 1'b0;
          s.skipping_error = 1'b1;
          s.bytes_held     = state_i.bytes_held + 3'd1;
          if (s.bytes_held >= MaxGroup) begin
            emit_a           = 1'b1;
            res_a.invalid    = 1'b1;
            res_a.byte_count = s.bytes_held;
            s                = Idle;
          end
        end else begin
          emit_a           = 1'b1;
          res_a.invalid    = 1'b1;
          res_a.byte_count = state_i.bytes_held;
          s                = Idle;
        end
      end else begin
        fresh           = 1'b0;
        s.partial_value = {state_i.partial_value[CpWidth-7:0], data_byte_i[5:0]};
        s.bytes_held    = state_i.bytes_held + 3'd1;
        if (s.bytes_held >= state_i.expected_length) begin
          emit_a           = 1'b1;
          res_a.code_point = s.partial_value;
          res_a.byte_count = s.bytes_held;
          s                = Idle;
        end
      end
    end

    // Start of a fresh decode
    if (fresh) begin
      priority if (data_byte_i <= AsciiMax) begin
        emit_b           = 1'b1;
        res_b.code_point = {{(CpWidth-8){1'b0}}, data_byte_i};
        res_b.byte_count = 3'd1;
      end else if ((data_byte_i >= Lead2Min) && (data_byte_i <= Lead2Max)) begin
        s.lead_byte       = data_byte_i;
        s.partial_value   = {{(CpWidth-8){1'b0}}, data_byte_i & Lead2Mask};
        s.expected_length = 3'd2;
        s.bytes_held      = 3'd1;
      end else if ((data_byte_i >= Lead3Min) && (data_byte_i <= Lead3Max)) begin
        s.lead_byte       = data_byte_i;
        s.partial_value   = {{(CpWidth-8){1'b0}}, data_byte_i & Lead3Mask};
        s.expected_length = 3'd3;
        s.bytes_held      = 3'd1;
      end else if ((data_byte_i >= Lead4Min) && (data_byte_i <= Lead4Max)) begin
        s.lead_byte       = data_byte_i;
        s.partial_value   = {{(CpWidth-8){1'b0}}, data_byte_i & Lead4Mask};
        s.expected_length = 3'd4;
        s.bytes_held      = 3'd1;
      end else begin
        s.skipping_error = 1'b1;
        s.bytes_held     = 3'd1;
      end
    end

    // End of text flushes whatever is pending
    if (end_of_text_i && (s.bytes_held != '0)) begin
      emit_c           = 1'b1;
      res_c.invalid    = 1'b1;
      res_c.byte_count = s.bytes_held;
      s                = Idle;
    end
  end

  // Order the results; the fresh ASCII result never comes with the flush one
  always_comb begin
    res0_o = '0;
    res1_o = '0;
    if (emit_a) begin
      res0_o    = res_a;
      res1_o    = emit_b ? res_b : res_c;
      res_num_o = (emit_b || emit_c) ? 2'd2 : 2'd1;
    end else if (emit_b) begin
      res0_o    = res_b;
      res_num_o = 2'd1;
    end else if (emit_c) begin
      res0_o    = res_c;
      res_num_o = 2'd1;
    end else begin
      res_num_o = 2'd0;
    end
    if (res_num_o == 2'd2) begin
      res1_o.last_of_run = 1'b1;
    end else begin
      res0_o.last_of_run = 1'b1;
    end
  end

  assign state_o = s;

endmodule

// File: rtl/utf8d_checker.sv
// Port-level checker for the UTF-8 validating decoder, bound to the top level.
`timescale 1ns / 1ps

module utf8d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [20:0] code_point_o,
  input logic        invalid_o,
  input logic [2:0]  byte_count_o,
  input logic        last_of_run_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_point_o) &&
    $stable(invalid_o) && $stable(byte_count_o) && $stable(last_of_run_o))
    else $error("result changed while stalled");

  // Invalid results carry no code point
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> code_point_o == 21'd0)
    else $error("invalid result with non-zero code point");

  // Every result covers one to four bytes
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_count_o != 3'd0 && byte_count_o <= 3'd4)
    else $error("byte count out of range");

  // Valid code points are scalar values, never surrogates
  a_scalar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !invalid_o |-> code_point_o <= 21'h10ffff &&
    (code_point_o < 21'h00d800 || code_point_o > 21'h00dfff))
    else $error("decoded value is not a scalar value");

  // Shortest form: the byte count matches the magnitude of the value
  a_shortest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !invalid_o |->
    (byte_count_o == 3'd1 && code_point_o <= 21'h7f) ||
    (byte_count_o == 3'd2 && code_point_o >= 21'h80 && code_point_o <= 21'h7ff) ||
    (byte_count_o == 3'd3 && code_point_o >= 21'h800 && code_point_o <= 21'hffff) ||
    (byte_count_o == 3'd4 && code_point_o >= 21'h10000))
    else $error("valid result not in shortest form");

endmodule

bind utf8_validating_decoder_core utf8d_checker u_utf8d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .code_point_o  (code_point_o),
  .invalid_o     (invalid_o),
  .byte_count_o  (byte_count_o),
  .last_of_run_o (last_of_run_o)
);
